@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker file rbl_checker.sv.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is held.
`define RBL_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that also runs across reset.
`define RBL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/rbl_pkg.sv @@
// ----------------------------------------------------------------------------
// rbl_pkg
// Shared types and constants of the 5x5 replicate-edge blur.
// ----------------------------------------------------------------------------
`default_nettype none

package rbl_pkg;

    localparam int PIX_W   = 24;
    localparam int KSIZE   = 5;
    localparam int NBANK   = 4;
    localparam int COL_W   = 12;
    localparam int ROW_W   = 13;
    localparam int CFG_W   = 13;
    localparam int SUM_W   = 14;
    localparam int RECIP_W = 15;

    // Divide by 51: sum * 20561 >> 20 is exact for sums up to 13005.
    localparam logic [RECIP_W-1:0] RECIP       = 15'd20561;
    localparam int                 RECIP_SHIFT = 20;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    localparam logic [COL_W-1:0] WIDTH_RESET  = 12'd640;
    localparam logic [ROW_W-1:0] HEIGHT_RESET = 13'd480;
    localparam logic [ROW_W-1:0] HEIGHT_MAX   = 13'd4096;

    localparam logic [3:0] BLUR_MASK [KSIZE][KSIZE] = '{
        '{4'd1, 4'd1, 4'd2, 4'd1, 4'd1},
        '{4'd1, 4'd2, 4'd4, 4'd2, 4'd1},
        '{4'd1, 4'd4, 4'd8, 4'd4, 4'd2},
        '{4'd1, 4'd2, 4'd4, 4'd2, 4'd1},
        '{4'd1, 4'd1, 4'd2, 4'd1, 4'd1}
    };

    typedef logic [PIX_W-1:0]        t_pix;
    typedef t_pix [KSIZE-1:0]        t_col;
    typedef t_col [KSIZE-1:0]        t_window;   // [row][column]

    typedef struct packed {
        logic       use_pix;
        logic [1:0] bank;
    } t_tap_sel;

    typedef struct packed {
        t_tap_sel [KSIZE-1:0] tap;
        logic                 first_col;
        logic                 last_col;
        logic [2:0]           emit;
        logic [2:0]           last_run;
        logic                 lof;
    } t_item_ctl;

    function automatic t_window shift_window(input t_window w, input t_col c);
        t_window r;
        for (int i = 0; i < KSIZE; i++) begin
            for (int j = 0; j < KSIZE - 1; j++) begin
                r[i][j] = w[i][j+1];
            end
            r[i][KSIZE-1] = c[i];
        end
        return r;
    endfunction

    function automatic t_window fill_window(input t_col c);
        t_window r;
        for (int i = 0; i < KSIZE; i++) begin
            for (int j = 0; j < KSIZE; j++) begin
                r[i][j] = c[i];
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/rbl_line_store.sv @@
// ----------------------------------------------------------------------------
// rbl_line_store
// Four row banks, all read at one column, one bank written per beat.
// ----------------------------------------------------------------------------
`default_nettype none

module rbl_line_store #(
    parameter int MAX_WIDTH = 2048
) (
    input  wire                               i_clk,
    input  wire                               i_en,
    input  wire                               i_we,
    input  wire  [$clog2(MAX_WIDTH)-1:0]      i_addr,
    input  wire  [1:0]                        i_wr_bank,
    input  wire  rbl_pkg::t_pix               i_wr_data,
    output rbl_pkg::t_pix                     o_rdata [rbl_pkg::NBANK]
);

    // read-before-write: the bank being written returns the row four above
    for (genvar b = 0; b < rbl_pkg::NBANK; b++) begin : g_bank
        rbl_pkg::t_pix r_mem [MAX_WIDTH];
        rbl_pkg::t_pix r_rdata;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rdata <= r_mem[i_addr];
                if (i_we && (i_wr_bank == 2'(b))) begin
                    r_mem[i_addr] <= i_wr_data;
                end
            end
        end
        assign o_rdata[b] = r_rdata;
    end

endmodule

`default_nettype wire

@@ hw/rtl/rbl_window.sv @@
// ----------------------------------------------------------------------------
// rbl_window
// 5x5 window: shifts in one column per beat, refills at the left edge and
// repeats the right-edge column for the two extra results of a row end.
// ----------------------------------------------------------------------------
`default_nettype none

module rbl_window (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_valid,
    input  wire  rbl_pkg::t_pix     i_pix,
    input  wire  rbl_pkg::t_item_ctl i_ctl,
    input  rbl_pkg::t_pix           i_rdata [rbl_pkg::NBANK],
    output logic                    o_take,
    input  wire                     i_ready,
    output logic                    o_emit,
    output rbl_pkg::t_window        o_win,
    output logic                    o_last_run,
    output logic                    o_lof
);

    rbl_pkg::t_window r_window, n_window;
    rbl_pkg::t_col    r_colv, n_colv, colv;
    logic [1:0]       r_rem, n_rem;
    logic [1:0]       r_emask, n_emask;
    logic [1:0]       r_lrq, n_lrq;
    logic [1:0]       r_lofq, n_lofq;
    logic             r_emit, n_emit;
    logic             r_last_run, n_last_run;
    logic             r_lof, n_lof;
    logic             adv;

    always_comb begin
        for (int i = 0; i < rbl_pkg::KSIZE; i++) begin
            colv[i] = i_ctl.tap[i].use_pix ? i_pix : i_rdata[i_ctl.tap[i].bank];
        end
    end

    assign adv = !r_emit || i_ready;

    always_comb begin
        n_window   = r_window;
        n_colv     = r_colv;
        n_rem      = r_rem;
        n_emask    = r_emask;
        n_lrq      = r_lrq;
        n_lofq     = r_lofq;
        n_emit     = r_emit;
        n_last_run = r_last_run;
        n_lof      = r_lof;
        o_take     = 1'b0;
        if (adv) begin
            if (r_rem != 2'd0) begin
                n_window   = rbl_pkg::shift_window(r_window, r_colv);
                n_rem      = r_rem - 2'd1;
                n_emit     = r_emask[0];
                n_last_run = r_lrq[0];
                n_lof      = r_lofq[0];
                n_emask    = {1'b0, r_emask[1]};
                n_lrq      = {1'b0, r_lrq[1]};
                n_lofq     = {1'b0, r_lofq[1]};
            end else if (i_valid) begin
                o_take     = 1'b1;
                n_colv     = colv;
                n_window   = i_ctl.first_col ? rbl_pkg::fill_window(colv)
                                             : rbl_pkg::shift_window(r_window, colv);
                n_emit     = i_ctl.emit[0];
                n_last_run = i_ctl.last_run[0];
                n_lof      = 1'b0;
                n_rem      = i_ctl.last_col ? 2'd2 : 2'd0;
                n_emask    = i_ctl.emit[2:1];
                n_lrq      = i_ctl.last_run[2:1];
                n_lofq     = {i_ctl.lof, 1'b0};
            end else begin
                n_emit = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem  <= 2'd0;
            r_emit <= 1'b0;
        end else begin
            r_rem  <= n_rem;
            r_emit <= n_emit;
        end
        r_window   <= n_window;
        r_colv     <= n_colv;
        r_emask    <= n_emask;
        r_lrq      <= n_lrq;
        r_lofq     <= n_lofq;
        r_last_run <= n_last_run;
        r_lof      <= n_lof;
    end

    assign o_emit     = r_emit;
    assign o_win      = r_window;
    assign o_last_run = r_last_run;
    assign o_lof      = r_lof;

endmodule

`default_nettype wire

@@ hw/rtl/rbl_filter.sv @@
// ----------------------------------------------------------------------------
// rbl_filter
// Weighted window sum per channel, then divide by 51 into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rbl_filter (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_valid,
    input  wire  rbl_pkg::t_window  i_win,
    input  wire                     i_last_run,
    input  wire                     i_lof,
    output logic                    o_ready,
    output logic                    o_valid,
    output rbl_pkg::t_pix           o_pix,
    output logic                    o_last_run,
    output logic                    o_lof,
    input  wire                     i_ready
);

    localparam int PROD_W = rbl_pkg::SUM_W + rbl_pkg::RECIP_W;

    // centre row weighs 19, so a row sum reaches 4845
    logic [12:0]               row_sum [3][rbl_pkg::KSIZE];
    logic [rbl_pkg::SUM_W-1:0] sum     [3];
    logic [rbl_pkg::SUM_W-1:0] r3_sum  [3];
    logic [PROD_W-1:0]         prod    [3];
    logic                      r3_v, r3_last_run, r3_lof;
    logic                      r4_v, r4_last_run, r4_lof;
    rbl_pkg::t_pix             r4_pix, n4_pix;
    logic                      s3_ready, s4_ready;

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            for (int i = 0; i < rbl_pkg::KSIZE; i++) begin
                row_sum[ch][i] = 13'd0;
                for (int j = 0; j < rbl_pkg::KSIZE; j++) begin
                    row_sum[ch][i] = row_sum[ch][i]
                        + 13'(rbl_pkg::BLUR_MASK[i][j]) * 13'(i_win[i][j][8*ch +: 8]);
                end
            end
            sum[ch] = '0;
            for (int i = 0; i < rbl_pkg::KSIZE; i++) begin
                sum[ch] = sum[ch] + rbl_pkg::SUM_W'(row_sum[ch][i]);
            end
        end
    end

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            prod[ch] = PROD_W'(r3_sum[ch]) * PROD_W'(rbl_pkg::RECIP);
            n4_pix[8*ch +: 8] = prod[ch][rbl_pkg::RECIP_SHIFT +: 8];
        end
    end

    assign s4_ready = !r4_v || i_ready;
    assign s3_ready = !r3_v || s4_ready;
    assign o_ready  = s3_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else begin
            if (s3_ready) r3_v <= i_valid;
            if (s4_ready) r4_v <= r3_v;
        end
        if (s3_ready) begin
            r3_sum      <= sum;
            r3_last_run <= i_last_run;
            r3_lof      <= i_lof;
        end
        if (s4_ready) begin
            r4_pix      <= n4_pix;
            r4_last_run <= r3_last_run;
            r4_lof      <= r3_lof;
        end
    end

    assign o_valid    = r4_v;
    assign o_pix      = r4_pix;
    assign o_last_run = r4_last_run;
    assign o_lof      = r4_lof;

endmodule

`default_nettype wire

@@ hw/rtl/rgb_blur_5x5_replicate.sv @@
// ----------------------------------------------------------------------------
// rgb_blur_5x5_replicate
// Streaming 5x5 blur of packed BGR pixels with edge replication.
// ----------------------------------------------------------------------------
// Pixels enter in raster order on the valid/ready input channel; after the
// frame the source sends 2*width drain beats to flush the last two rows.
// Blurred pixels leave in raster order on the valid/ready output channel,
// two rows and two columns behind the input; the beat at the last column of
// a row releases up to three results, so the input is held while the window
// repeats the right-edge column. Throughput: one input beat per cycle when
// the output is not stalled, apart from that hold. Each beat passes through
// line-store read, window shift, sum and divide into the output register.
// Width and height are written on the config port while idle; any write
// restarts the frame. Reset clears the pipeline and loads 640 x 480; line
// stores keep old contents and are always written before they are read.
// A stalled receiver fills the four pipeline registers, then ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_blur_5x5_replicate #(
    parameter int MAX_WIDTH = 2048
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_valid,
    output logic                          o_ready,
    input  wire  [rbl_pkg::PIX_W-1:0]     i_pixel,
    input  wire                           i_is_drain,
    output logic                          o_valid,
    input  wire                           i_ready,
    output logic [rbl_pkg::PIX_W-1:0]     o_filtered_pixel,
    output logic                          o_last_of_frame,
    output logic                          o_last_of_run,
    input  wire                           i_cfg_we,
    input  wire                           i_cfg_idx,
    input  wire  [rbl_pkg::CFG_W-1:0]     i_cfg_data
);

    localparam int ADDR_W = $clog2(MAX_WIDTH);
    localparam int WCAP   = (MAX_WIDTH > 4095) ? 4095 : MAX_WIDTH;
    localparam int SROW_W = rbl_pkg::ROW_W + 2;

    logic [rbl_pkg::COL_W-1:0] r_width, r_col, n_col, uw, cc, c1;
    logic [rbl_pkg::ROW_W-1:0] r_height, r_row, n_row, uh, kk, k1;
    logic                      r_run;
    logic                      r1_v;
    rbl_pkg::t_pix             r1_pix;
    rbl_pkg::t_item_ctl        r1_ctl, n_ctl;
    logic                      accept, wrap, real_row, s1_take;
    logic [SROW_W-1:0]         rs;
    logic [rbl_pkg::ROW_W-1:0] rr;
    rbl_pkg::t_pix             rdata [rbl_pkg::NBANK];
    logic                      w_emit, w_last_run, w_lof, f_ready;
    rbl_pkg::t_window          w_win;

    // used geometry
    always_comb begin
        priority if (r_width == '0)               uw = 12'd1;
        else if (r_width > 12'(WCAP))             uw = 12'(WCAP);
        else                                      uw = r_width;
        priority if (r_height == '0)              uh = 13'd1;
        else if (r_height > rbl_pkg::HEIGHT_MAX)  uh = rbl_pkg::HEIGHT_MAX;
        else                                      uh = r_height;
    end

    assign wrap     = (r_col >= uw) || ({1'b0, r_row} >= ({1'b0, uh} + 14'd2));
    assign cc       = wrap ? '0 : r_col;
    assign kk       = wrap ? '0 : r_row;
    assign real_row = kk < uh;
    assign accept   = i_valid && o_ready;
    assign o_ready  = r_run && (!r1_v || s1_take);

    always_comb begin
        rs = '0;
        rr = '0;
        for (int i = 0; i < rbl_pkg::KSIZE; i++) begin
            rs = SROW_W'(kk) + SROW_W'(i) - SROW_W'(4);
            if (rs[SROW_W-1])                            rr = '0;
            else if (rs > SROW_W'(uh) - SROW_W'(1))      rr = uh - 13'd1;
            else                                         rr = rbl_pkg::ROW_W'(rs);
            n_ctl.tap[i].use_pix = real_row && (rr == kk);
            n_ctl.tap[i].bank    = rr[1:0];
        end
        n_ctl.first_col   = (cc == '0);
        n_ctl.last_col    = (cc == uw - 12'd1);
        n_ctl.emit[0]     = (kk >= 13'd2) && (cc >= 12'd2);
        n_ctl.emit[1]     = (kk >= 13'd2) && n_ctl.last_col && (cc >= 12'd1);
        n_ctl.emit[2]     = (kk >= 13'd2) && n_ctl.last_col;
        n_ctl.last_run[2] = n_ctl.emit[2];
        n_ctl.last_run[1] = n_ctl.emit[1] && !n_ctl.emit[2];
        n_ctl.last_run[0] = n_ctl.emit[0] && !n_ctl.emit[1] && !n_ctl.emit[2];
        n_ctl.lof         = n_ctl.emit[2] && ({1'b0, kk} == ({1'b0, uh} + 14'd1));
    end

    // raster counters
    always_comb begin
        c1    = cc + 12'd1;
        k1    = kk + 13'd1;
        n_col = c1;
        n_row = kk;
        if (c1 >= uw) begin
            n_col = '0;
            n_row = ({1'b0, k1} >= ({1'b0, uh} + 14'd2)) ? '0 : k1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= rbl_pkg::WIDTH_RESET;
            r_height <= rbl_pkg::HEIGHT_RESET;
            r_col    <= '0;
            r_row    <= '0;
            r_run    <= 1'b0;
            r1_v     <= 1'b0;
        end else begin
            r_run <= 1'b1;
            if (i_cfg_we) begin
                if (i_cfg_idx == rbl_pkg::REG_WIDTH) r_width  <= i_cfg_data[11:0];
                else                                 r_height <= i_cfg_data;
                r_col <= '0;
                r_row <= '0;
            end else if (accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (accept)       r1_v <= 1'b1;
            else if (s1_take) r1_v <= 1'b0;
        end
        if (accept) begin
            r1_pix <= i_pixel;
            r1_ctl <= n_ctl;
        end
    end

    rbl_line_store #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_en      (accept),
        .i_we      (accept && real_row),
        .i_addr    (ADDR_W'(cc)),
        .i_wr_bank (kk[1:0]),
        .i_wr_data (i_pixel),
        .o_rdata   (rdata)
    );

    rbl_window u_window (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r1_v),
        .i_pix      (r1_pix),
        .i_ctl      (r1_ctl),
        .i_rdata    (rdata),
        .o_take     (s1_take),
        .i_ready    (f_ready),
        .o_emit     (w_emit),
        .o_win      (w_win),
        .o_last_run (w_last_run),
        .o_lof      (w_lof)
    );

    rbl_filter u_filter (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_emit),
        .i_win      (w_win),
        .i_last_run (w_last_run),
        .i_lof      (w_lof),
        .o_ready    (f_ready),
        .o_valid    (o_valid),
        .o_pix      (o_filtered_pixel),
        .o_last_run (o_last_of_run),
        .o_lof      (o_last_of_frame),
        .i_ready    (i_ready)
    );

endmodule

`default_nettype wire

@@ hw/rtl/rbl_checker.sv @@
// ----------------------------------------------------------------------------
// rbl_checker
// Port-level checks of the blur, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rbl_checker (
    input wire                        i_clk,
    input wire                        i_rst_n,
    input wire                        i_valid,
    input wire                        o_ready,
    input wire                        o_valid,
    input wire                        i_ready,
    input wire [rbl_pkg::PIX_W-1:0]   o_filtered_pixel,
    input wire                        o_last_of_frame,
    input wire                        o_last_of_run
);

    `RBL_ASSERT_ALWAYS(a_rst_idle, i_clk, !i_rst_n |=> !o_valid, "output beat right after reset")
    `RBL_ASSERT(a_lof_ends_run, i_clk, i_rst_n, o_valid && o_last_of_frame |-> o_last_of_run, "frame end not last of run")
    `RBL_ASSERT(a_ready_holds, i_clk, i_rst_n, o_ready && !i_valid |=> o_ready, "ready dropped with no beat taken")
    `RBL_ASSERT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready |=> o_valid && $stable(o_filtered_pixel), "stalled output beat changed")

endmodule

bind rgb_blur_5x5_replicate rbl_checker u_rbl_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_valid          (i_valid),
    .o_ready          (o_ready),
    .o_valid          (o_valid),
    .i_ready          (i_ready),
    .o_filtered_pixel (o_filtered_pixel),
    .o_last_of_frame  (o_last_of_frame),
    .o_last_of_run    (o_last_of_run)
);

`default_nettype wire
